### hw/rtl/vc1su_pkg.sv
// Shared types and constants for the VC-1 start-code splitter and unescaper.
// No dependencies; imported by vc1su_proc, vc1su_queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package vc1su_pkg;

	localparam int MAX_RESULTS   = 4;          // results one byte can release
	localparam int HOLD_DEPTH    = 4;
	localparam int QUEUE_DEPTH_D = 8;          // default output queue depth

	localparam logic [23:0] PREFIX_PATTERN = 24'h000001;
	localparam logic [23:0] WINDOW_INIT    = 24'hFFFFFF;
	localparam logic [7:0]  ESCAPE_BYTE    = 8'h03;
	localparam logic [7:0]  ESCAPE_LIMIT   = 8'h04;
	localparam logic [1:0]  POS_FULL       = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] code;
		logic       last;
	} vc1su_result_t;

	// Results produced by one processed byte, in order from index 0
	typedef struct packed {
		logic [2:0]                        count;
		vc1su_result_t [MAX_RESULTS-1:0]   res;
	} vc1su_push_t;

endpackage

`default_nettype wire

### hw/rtl/vc1su_proc.sv
// Per-byte start-code search, segment hold line and escape removal.
// Depends on vc1su_pkg; state advances only when fire is high.
`timescale 1ns / 1ps
`default_nettype none

module vc1su_proc
	import vc1su_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  byte_s1,
	input  wire logic        eod_s1,
	output vc1su_push_t      push
);

	logic [7:0]  hold_q [HOLD_DEPTH];
	logic [2:0]  hold_cnt_q;
	logic [23:0] win_q;
	logic        in_seg_q;
	logic [7:0]  code_q;
	logic [1:0]  pos_q;
	logic [15:0] prior_q;
	logic        pass_q;

	logic [7:0]  hold_d [HOLD_DEPTH];
	logic [2:0]  hold_cnt_d;
	logic [23:0] win_d;
	logic        in_seg_d;
	logic [7:0]  code_d;
	logic [1:0]  pos_d;
	logic [15:0] prior_d;
	logic        pass_d;

	logic        hit;
	logic [23:0] win_sh;
	logic [2:0]  flush_k;
	logic        shift_one;
	logic        has_nx;
	logic [7:0]  cur_b;
	logic [7:0]  nx_b;
	logic        removable;
	logic [2:0]  n;
	vc1su_push_t push_c;

	always_comb begin
		hold_d     = hold_q;
		hold_cnt_d = hold_cnt_q;
		in_seg_d   = in_seg_q;
		code_d     = code_q;
		pos_d      = pos_q;
		prior_d    = prior_q;
		pass_d     = pass_q;
		push_c     = '0;
		n          = '0;
		flush_k    = '0;
		shift_one  = 1'b0;
		has_nx     = 1'b0;
		cur_b      = '0;
		nx_b       = '0;
		removable  = 1'b0;

		hit    = (win_q == PREFIX_PATTERN);
		win_sh = {win_q[15:0], byte_s1};
		win_d  = win_sh;

		if (hit) begin
			// close the open segment: the three prefix bytes in the hold line are not payload
			if (in_seg_q && hold_cnt_q >= 3'd3) begin
				flush_k = hold_cnt_q - 3'd3;
			end
		end else if (in_seg_q) begin
			if (hold_cnt_q < 3'(HOLD_DEPTH)) begin
				hold_d[hold_cnt_q[1:0]] = byte_s1;
				hold_cnt_d = hold_cnt_q + 3'd1;
			end
			if (eod_s1) begin
				flush_k = hold_cnt_d;
			end else if (hold_cnt_d == 3'(HOLD_DEPTH) && win_sh != PREFIX_PATTERN) begin
				flush_k   = 3'd1;
				shift_one = 1'b1;
			end
		end

		for (int i = 0; i < HOLD_DEPTH; i++) begin
			if (3'(i) < flush_k) begin
				cur_b  = hold_d[2'(i)];
				has_nx = (3'(i + 1) < flush_k) || shift_one;
				nx_b   = hold_d[2'(i + 1)];
				removable = !pass_d && cur_b == ESCAPE_BYTE && pos_d == POS_FULL &&
					prior_d == 16'h0000 && has_nx && nx_b < ESCAPE_LIMIT;
				if (removable) begin
					pass_d = 1'b1;
				end else begin
					push_c.res[n[1:0]] = '{data: cur_b, code: code_q, last: !has_nx};
					n      = n + 3'd1;
					pass_d = 1'b0;
				end
				prior_d = {prior_d[7:0], cur_b};
				if (pos_d != POS_FULL) begin
					pos_d = pos_d + 2'd1;
				end
			end
		end
		push_c.count = n;

		if (shift_one) begin
			for (int j = 0; j < HOLD_DEPTH - 1; j++) begin
				hold_d[j] = hold_d[j + 1];
			end
			hold_cnt_d = 3'(HOLD_DEPTH - 1);
		end else if (flush_k != 3'd0) begin
			hold_cnt_d = '0;
		end

		if (hit) begin
			in_seg_d   = 1'b1;
			code_d     = byte_s1;
			hold_cnt_d = '0;
			win_d      = WINDOW_INIT;
			pos_d      = '0;
			prior_d    = '0;
			pass_d     = 1'b0;
		end

		// end of data: start a fresh stream
		if (eod_s1) begin
			hold_cnt_d = '0;
			win_d      = WINDOW_INIT;
			in_seg_d   = 1'b0;
			code_d     = '0;
			pos_d      = '0;
			prior_d    = '0;
			pass_d     = 1'b0;
		end
	end

	always_comb begin
		push = push_c;
		if (!fire) begin
			push.count = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt_q <= '0;
			win_q      <= WINDOW_INIT;
			in_seg_q   <= 1'b0;
			code_q     <= '0;
			pos_q      <= '0;
			prior_q    <= '0;
			pass_q     <= 1'b0;
		end else if (fire) begin
			hold_cnt_q <= hold_cnt_d;
			win_q      <= win_d;
			in_seg_q   <= in_seg_d;
			code_q     <= code_d;
			pos_q      <= pos_d;
			prior_q    <= prior_d;
			pass_q     <= pass_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hold_q <= hold_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/vc1su_queue.sv
// Output queue: takes up to MAX_RESULTS results a cycle, releases one a cycle while head_ready is high.
// Depends on vc1su_pkg; head entry sits at index zero.
`timescale 1ns / 1ps
`default_nettype none

module vc1su_queue
	import vc1su_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire vc1su_push_t push,
	output logic             room,
	output logic             head_valid,
	input  wire logic        head_ready,
	output vc1su_result_t    head
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	vc1su_result_t entry_q [DEPTH];
	vc1su_result_t entry_d [DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_a;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] wr_idx;
	logic             pop;

	assign pop        = (cnt_q != '0) && head_ready;
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[0];
	// a new request is taken only when a full burst of results still fits
	assign room       = cnt_q <= CNT_W'(DEPTH - MAX_RESULTS);

	always_comb begin
		entry_d = entry_q;
		wr_idx  = '0;
		cnt_a   = cnt_q - CNT_W'(pop);
		if (pop) begin
			for (int j = 0; j < DEPTH - 1; j++) begin
				entry_d[j] = entry_q[j + 1];
			end
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (3'(i) < push.count) begin
				wr_idx = cnt_a + CNT_W'(i);
				entry_d[wr_idx[IDX_W-1:0]] = push.res[i];
			end
		end
		cnt_d = cnt_a + CNT_W'(push.count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

`default_nettype wire

### hw/rtl/vc1_start_code_unescape_top.sv
// A byte is registered on acceptance and processed once the output queue has room; a payload
// byte leaves once three later bytes (four behind a pending 00 00 01) or the segment end arrive.
// Throughput: one byte per cycle; input stalls only while the output queue holds more than
// QUEUE_DEPTH - 4 results (one byte can release up to four at end of data).
// Reset: arst_n clears all control state at once; hold line and queue data are not cleared.
// Depends on vc1su_pkg, vc1su_proc and vc1su_queue.
`timescale 1ns / 1ps
`default_nettype none

module vc1_start_code_unescape_top
	import vc1su_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] raw_byte
	input  wire logic       s_axis_tlast,   // end_of_data
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [7:0]      m_axis_tuser,   // [7:0] segment_code
	output logic            m_axis_tlast    // segment_last
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          eod_s1;
	logic          room;
	logic          fire;
	vc1su_push_t   push;
	vc1su_result_t head;

	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eod_s1  <= s_axis_tlast;
		end
	end

	vc1su_proc u_proc (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.eod_s1  (eod_s1),
		.push    (push)
	);

	vc1su_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (m_axis_tvalid),
		.head_ready (m_axis_tready),
		.head       (head)
	);

	assign m_axis_tdata = head.data;
	assign m_axis_tuser = head.code;
	assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

### hw/rtl/vc1su_checker.sv
// Port-level checks for the start-code unescaper, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module vc1su_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       s_axis_tlast,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic [7:0] m_axis_tuser,
	input wire logic       m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("stalled result changed");

	// with nothing queued the input side never stalls
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output queue");

	// results out of an empty queue trace back to an accepted request, through the input register and the queue
	a_first_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result appeared without a matching request");

	// end of data flushes everything, so an idle output stays idle unless new input came
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=>
		!$rose(m_axis_tvalid) || $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result appeared with no request in flight");

endmodule

bind vc1_start_code_unescape_top vc1su_checker u_vc1su_checker (.*);

`default_nettype wire

### tb/tb.sv
// Testbench for vc1_start_code_unescape_top: start-code splitting and 03 escape removal.
// Streams raw bytes with random gaps and checks every payload byte against a local predictor.
// Depends on vc1su_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import vc1su_pkg::*;

	localparam int IDLE_PCT    = 27;
	localparam int RAND_BYTES  = 310;
	localparam int HOLDOFF_LEN = 150;
	localparam int WDOG_LIMIT  = 1000;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		logic [7:0] b;
		logic       eod;
		bit         wait_drain;
	} raw_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [7:0] m_axis_tuser;
	logic       m_axis_tlast;

	raw_req_t      raw_reqs[$];
	vc1su_result_t pending_payload[$];

	// predictor state
	logic [7:0]  hl[4];
	logic [2:0]  hcnt;
	logic [23:0] win;
	bit          seg_open;
	logic [7:0]  seg_code;
	logic [1:0]  pos;
	logic [15:0] prev2;
	bit          skip_chk;

	int  n_in, n_out, n_bad, n_escapes, n_segments;
	int  idle_cycles;
	int  hold_left;
	bit  holdoff_done;
	bit  took = 1'b0;
	wire quiet = (n_in >= 150) && (n_in < 230);

	vc1_start_code_unescape_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] raw_byte
		.s_axis_tlast  (s_axis_tlast),   // end_of_data
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
		.m_axis_tuser  (m_axis_tuser),   // [7:0] segment_code
		.m_axis_tlast  (m_axis_tlast)    // segment_last
	);

	always #1 clk = ~clk;

	function automatic void clear_stream();
		for (int i = 0; i < 4; i++) hl[i] = 8'h00;
		hcnt     = 3'd0;
		win      = WINDOW_INIT;
		seg_open = 1'b0;
		seg_code = 8'h00;
		pos      = 2'd0;
		prev2    = 16'h0000;
		skip_chk = 1'b0;
	endfunction

	// Drop an escape 03 or release the byte as payload.
	function automatic void decide_byte(input logic [7:0] b, input bit has_nxt,
			input logic [7:0] nxt);
		vc1su_result_t r;
		bit            drop;
		drop = !skip_chk && b == ESCAPE_BYTE && pos >= POS_FULL && prev2 == 16'h0000 &&
			has_nxt && nxt < ESCAPE_LIMIT;
		if (drop) begin
			skip_chk = 1'b1;
			n_escapes++;
		end else begin
			r.data = b;
			r.code = seg_code;
			r.last = !has_nxt;
			pending_payload.push_back(r);
			skip_chk = 1'b0;
		end
		prev2 = {prev2[7:0], b};
		if (pos < POS_FULL) pos++;
	endfunction

	function automatic void flush_held(input int k);
		for (int i = 0; i < k; i++)
			decide_byte(hl[i], (i + 1) < k, ((i + 1) < k) ? hl[i + 1] : 8'h00);
		hcnt = 3'd0;
	endfunction

	function automatic void unescape_byte(input logic [7:0] b, input logic eod);
		bit hit;
		bit pend;
		hit = (win == PREFIX_PATTERN);
		win = {win[15:0], b};
		if (hit) begin
			if (seg_open) flush_held((hcnt >= 3) ? int'(hcnt) - 3 : 0);
			seg_open = 1'b1;
			seg_code = b;
			hcnt     = 3'd0;
			win      = WINDOW_INIT;
			pos      = 2'd0;
			prev2    = 16'h0000;
			skip_chk = 1'b0;
			n_segments++;
		end else if (seg_open) begin
			if (hcnt < 4) begin
				hl[hcnt[1:0]] = b;
				hcnt++;
			end
			pend = (win == PREFIX_PATTERN);
			if (eod) begin
				flush_held(int'(hcnt));
			end else if (hcnt == 4 && !pend) begin
				decide_byte(hl[0], 1'b1, hl[1]);
				hl[0] = hl[1];
				hl[1] = hl[2];
				hl[2] = hl[3];
				hcnt  = 3'd3;
			end
		end
		if (eod) clear_stream();
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic eod);
		raw_req_t q;
		q.b          = b;
		q.eod        = eod;
		q.wait_drain = 1'b0;
		raw_reqs.push_back(q);
	endtask

	function automatic logic [7:0] payload_byte();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40) return 8'h00;
		if (sel < 55) return ESCAPE_BYTE;
		if (sel < 65) return 8'h01;
		if (sel < 70) return 8'h02;
		return 8'($urandom_range(255));
	endfunction

	// request tracker: predict on every accepted input byte
	always @(posedge clk) begin
		took <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			unescape_byte(raw_reqs[0].b, raw_reqs[0].eod);
			raw_reqs.pop_front();
			n_in++;
		end
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || took) begin
				if (raw_reqs.size() != 0 &&
						!(raw_reqs[0].wait_drain && pending_payload.size() != 0) &&
						(quiet || $urandom_range(99) >= IDLE_PCT)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= raw_reqs[0].b;
					s_axis_tlast  <= raw_reqs[0].eod;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output ready, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!holdoff_done && n_in >= 60) begin
			holdoff_done <= 1'b1;
			hold_left <= HOLDOFF_LEN;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_out++;
			if (pending_payload.size() == 0) begin
				$error("unexpected result: byte %02h code %02h last %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				n_bad++;
			end else begin
				if (m_axis_tdata !== pending_payload[0].data) begin
					$error("out_byte expected %02h actual %02h",
						pending_payload[0].data, m_axis_tdata);
					n_bad++;
				end
				if (m_axis_tuser !== pending_payload[0].code) begin
					$error("segment_code expected %02h actual %02h",
						pending_payload[0].code, m_axis_tuser);
					n_bad++;
				end
				if (m_axis_tlast !== pending_payload[0].last) begin
					$error("segment_last expected %0b actual %0b",
						pending_payload[0].last, m_axis_tlast);
					n_bad++;
				end
				pending_payload.pop_front();
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int  seg_bytes;
		int  len;
		bit  drain_set;
		n_in = 0; n_out = 0; n_bad = 0; n_escapes = 0; n_segments = 0;
		idle_cycles = 0; hold_left = 0; holdoff_done = 1'b0;
		seg_bytes = 0; drain_set = 1'b0;
		clear_stream();

		// garbage ahead of the first code is dropped
		push_byte(8'hA5, 1'b0);
		// code 00; the window restarts so the following 00 01 stays payload
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
		// 00 00 03 01: the 03 goes away
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h03, 1'b0); push_byte(8'h01, 1'b0);
		// next code, then an empty segment
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0); push_byte(8'hB5, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0); push_byte(8'hE0, 1'b0);
		// trailing prefix without its code byte is flushed as payload
		push_byte(8'h7F, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b1);
		// fresh stream: garbage, then a code that ends the data at once
		push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
		push_byte(8'hFF, 1'b1);

		while (raw_reqs.size() < RAND_BYTES) begin
			// noise and broken prefixes
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
				push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
				push_byte(8'($urandom_range(2, 255)), 1'b0);
			end
			push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
			push_byte(8'h01, 1'b0); push_byte(8'($urandom_range(255)), 1'b0);
			len = ($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			for (int i = 0; i < len; i++) push_byte(payload_byte(), 1'b0);
			if ($urandom_range(4) == 0) begin
				// end the stream, sometimes on a dangling prefix
				if ($urandom_range(2) == 0) begin
					push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
					len += 3;
				end
				raw_reqs[$].eod = 1'b1;
			end
			seg_bytes += 4 + len;
			if (!drain_set && seg_bytes >= 200) begin
				drain_set = 1'b1;
				raw_reqs[$].wait_drain = 1'b1;
			end
		end
		raw_reqs[$].eod = 1'b1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (raw_reqs.size() != 0 || pending_payload.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_payload.size() != 0) begin
			$error("%0d payload bytes never arrived", pending_payload.size());
			n_bad++;
		end
		$display("Streamed %0d raw bytes over %0d segments with random gaps and back-pressure;",
			n_in, n_segments);
		$display("checked %0d payload bytes, %0d escape bytes removed.", n_out, n_escapes);
		if (n_bad == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
